@@ rtl/rdf_pkg.sv @@
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared types, codes and constants of the radix digit formatter.
// ----------------------------------------------------------------------------
package rdf_pkg;

  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned BCD_BITS   = 4 * BCD_DIGITS;

  typedef enum logic [1:0] {
    BASE_HEX = 2'd0,
    BASE_DEC = 2'd1,
    BASE_OCT = 2'd2,
    BASE_BIN = 2'd3
  } rdf_base_e;

  typedef enum logic [2:0] {
    CFG_NUMBER_BASE       = 3'd0,
    CFG_GROUP_SIZE        = 3'd1,
    CFG_SEPARATOR_CHAR    = 3'd2,
    CFG_UPPERCASE_HEX     = 3'd3,
    CFG_HEX_LEADING_ZERO  = 3'd4,
    CFG_SMALL_HEX_DECIMAL = 3'd5,
    CFG_OCTAL_ZERO_PREFIX = 3'd6
  } rdf_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_COUNT,
    ST_DABBLE,
    ST_ADJUST,
    ST_GROUP,
    ST_DIGIT,
    ST_SEP
  } rdf_state_e;

  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] HEX_UPPER_OFFS = 8'h37;  // 'A' - 10
  localparam logic [7:0] HEX_LOWER_OFFS = 8'h57;  // 'a' - 10

  // Control of the shared shift unit.
  typedef struct packed {
    logic load;
    logic count;
    logic dabble;
  } rdf_conv_ctrl_t;

  // One character request toward the word packer.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } rdf_char_req_t;

  // Digit count of a padded number for a given base and operand size.
  function automatic logic [6:0] pad_digits(rdf_base_e base, logic [1:0] size);
    logic [6:0] res;
    res = 7'd1;
    case (base)
      BASE_HEX: begin
        case (size)
          2'd0:    res = 7'd2;
          2'd1:    res = 7'd4;
          2'd2:    res = 7'd8;
          default: res = 7'd16;
        endcase
      end
      BASE_OCT: begin
        case (size)
          2'd0:    res = 7'd3;
          2'd1:    res = 7'd6;
          2'd2:    res = 7'd11;
          default: res = 7'd22;
        endcase
      end
      BASE_BIN: begin
        case (size)
          2'd0:    res = 7'd8;
          2'd1:    res = 7'd16;
          2'd2:    res = 7'd32;
          default: res = 7'd64;
        endcase
      end
      default: res = 7'd1;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/radix_digit_formatter_core.sv @@
// Sequence: accept, sign, then digit counting (skipped when padded; for decimal the bit-serial
// shift unit builds the digits instead), adjust, group reduction, and one character per digit or
// separator (at most 127); the last word then leaves through the packer's output register.
// Throughput: one number at a time, set by the shared shift unit and the packer, which takes
// one character per cycle while the output is not back-pressured.
// Reset (rst_ni low, asynchronous): configuration returns to its defaults, the output is empty.
// ----------------------------------------------------------------------------
// radix_digit_formatter_core
// Converts an 8- to 64-bit integer to ASCII text in base 16, 10, 8 or 2 with
// optional digit grouping, and streams the text out up to eight characters a word.
// ----------------------------------------------------------------------------
module radix_digit_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // value[63:0]
  input  logic [3:0]  s_axis_tuser,   // size_code[1:0], is_signed[2], pad_full_width[3]
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // chars[63:0], char_count[67:64], zero[71:68]
  output logic        m_axis_tlast    // last
);

  // Configuration registers.
  rdf_pkg::rdf_base_e base_q;
  logic [6:0]         group_q;
  logic [7:0]         sep_char_q;
  logic               upper_q;
  logic               hex_lz_q;
  logic               small_hex_q;
  logic               oct_pfx_q;

  rdf_pkg::rdf_state_e state_q, state_d;
  logic                neg_q, neg_d;
  logic                pad_q, pad_d;
  logic [1:0]          size_q, size_d;
  logic [63:0]         mag_q, mag_d;
  logic [6:0]          digits_q, digits_d;
  logic [5:0]          pos_q, pos_d;
  logic [6:0]          rem_q, rem_d;
  logic [5:0]          iter_q, iter_d;
  logic                sep_en_q, sep_en_d;

  rdf_pkg::rdf_conv_ctrl_t conv_ctrl;
  rdf_pkg::rdf_char_req_t  chr_req;
  logic                    chr_ready;
  logic                    rest_zero;
  logic [rdf_pkg::BCD_BITS-1:0] bcd;

  // Input decode.
  logic [63:0] raw, mask, mag_in;
  logic        sign_bit;

  // Digit selection.
  logic [5:0]  pos_sel;
  logic [63:0] hex_sh, oct_sh, bin_sh;
  logic [rdf_pkg::BCD_BITS-1:0] dec_sh;
  logic [3:0]  dsel;
  logic [7:0]  dchar;
  logic [4:0]  dec_len;
  logic        small_hit;
  logic [6:0]  dfin;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= rdf_pkg::BASE_HEX;
      group_q     <= '0;
      sep_char_q  <= '0;
      upper_q     <= 1'b1;
      hex_lz_q    <= 1'b0;
      small_hex_q <= 1'b0;
      oct_pfx_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rdf_pkg::CFG_NUMBER_BASE:       base_q      <= rdf_pkg::rdf_base_e'(cfg_data_i[1:0]);
        rdf_pkg::CFG_GROUP_SIZE:        group_q     <= cfg_data_i[6:0];
        rdf_pkg::CFG_SEPARATOR_CHAR:    sep_char_q  <= cfg_data_i;
        rdf_pkg::CFG_UPPERCASE_HEX:     upper_q     <= cfg_data_i[0];
        rdf_pkg::CFG_HEX_LEADING_ZERO:  hex_lz_q    <= cfg_data_i[0];
        rdf_pkg::CFG_SMALL_HEX_DECIMAL: small_hex_q <= cfg_data_i[0];
        rdf_pkg::CFG_OCTAL_ZERO_PREFIX: oct_pfx_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (s_axis_tuser[1:0])
      2'd0: begin
        mask     = 64'h0000_0000_0000_00FF;
        sign_bit = s_axis_tdata[7];
      end
      2'd1: begin
        mask     = 64'h0000_0000_0000_FFFF;
        sign_bit = s_axis_tdata[15];
      end
      2'd2: begin
        mask     = 64'h0000_0000_FFFF_FFFF;
        sign_bit = s_axis_tdata[31];
      end
      default: begin
        mask     = 64'hFFFF_FFFF_FFFF_FFFF;
        sign_bit = s_axis_tdata[63];
      end
    endcase
    raw    = s_axis_tdata & mask;
    mag_in = (s_axis_tuser[2] && sign_bit) ? ((~raw + 64'd1) & mask) : raw;
  end

  // Digit at pos_sel of the current base; positions past the value read zero.
  assign pos_sel = (state_q == rdf_pkg::ST_ADJUST) ? 6'(digits_q - 7'd1) : pos_q;
  assign hex_sh  = mag_q >> {pos_sel[3:0], 2'b00};
  assign oct_sh  = mag_q >> ({2'b00, pos_sel[4:0]} + {1'b0, pos_sel[4:0], 1'b0});
  assign bin_sh  = mag_q >> pos_sel;
  assign dec_sh  = bcd >> {pos_sel[4:0], 2'b00};

  always_comb begin
    case (base_q)
      rdf_pkg::BASE_HEX: dsel = (pos_sel < 6'd16) ? hex_sh[3:0] : 4'd0;
      rdf_pkg::BASE_DEC: dsel = (pos_sel < 6'd20) ? dec_sh[3:0] : 4'd0;
      rdf_pkg::BASE_OCT: dsel = (pos_sel < 6'd22) ? {1'b0, oct_sh[2:0]} : 4'd0;
      default:           dsel = {3'b000, bin_sh[0]};
    endcase
    if (dsel > 4'd9) begin
      dchar = {4'd0, dsel} + (upper_q ? rdf_pkg::HEX_UPPER_OFFS : rdf_pkg::HEX_LOWER_OFFS);
    end else begin
      dchar = {4'd0, dsel} + rdf_pkg::CHAR_ZERO;
    end
  end

  // Length of the decimal number: highest nonzero digit, at least one digit.
  always_comb begin
    dec_len = 5'd1;
    for (int k = 0; k < rdf_pkg::BCD_DIGITS; k++) begin
      if (bcd[4*k +: 4] != 4'd0) begin
        dec_len = 5'(k + 1);
      end
    end
  end

  assign small_hit = (base_q == rdf_pkg::BASE_HEX) && small_hex_q && (mag_q <= 64'd9);

  always_comb begin
    case (base_q)
      rdf_pkg::BASE_DEC: dfin = {2'b00, dec_len};
      rdf_pkg::BASE_HEX: begin
        if (small_hit) begin
          dfin = 7'd1;
        end else begin
          dfin = digits_q + {6'd0, hex_lz_q && (digits_q < 7'd17) && (dsel > 4'd9)};
        end
      end
      rdf_pkg::BASE_OCT:
        dfin = digits_q + {6'd0, oct_pfx_q && (digits_q < 7'd23) && (dsel != 4'd0)};
      default: dfin = digits_q;
    endcase
  end

  always_comb begin
    state_d       = state_q;
    neg_d         = neg_q;
    pad_d         = pad_q;
    size_d        = size_q;
    mag_d         = mag_q;
    digits_d      = digits_q;
    pos_d         = pos_q;
    rem_d         = rem_q;
    iter_d        = iter_q;
    sep_en_d      = sep_en_q;
    conv_ctrl     = '0;
    chr_req       = '0;
    s_axis_tready = 1'b0;

    case (state_q)
      rdf_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          neg_d          = s_axis_tuser[2] && sign_bit;
          size_d         = s_axis_tuser[1:0];
          pad_d          = s_axis_tuser[3];
          mag_d          = mag_in;
          conv_ctrl.load = 1'b1;
          state_d        = rdf_pkg::ST_SIGN;
        end
      end

      rdf_pkg::ST_SIGN: begin
        chr_req.valid = neg_q;
        chr_req.data  = rdf_pkg::CHAR_MINUS;
        if (!neg_q || chr_ready) begin
          if (base_q == rdf_pkg::BASE_DEC) begin
            iter_d  = '0;
            state_d = rdf_pkg::ST_DABBLE;
          end else if (pad_q) begin
            digits_d = rdf_pkg::pad_digits(base_q, size_q);
            state_d  = rdf_pkg::ST_ADJUST;
          end else begin
            digits_d = 7'd1;
            state_d  = rdf_pkg::ST_COUNT;
          end
        end
      end

      rdf_pkg::ST_COUNT: begin
        if (rest_zero) begin
          state_d = rdf_pkg::ST_ADJUST;
        end else begin
          conv_ctrl.count = 1'b1;
          digits_d        = digits_q + 7'd1;
        end
      end

      rdf_pkg::ST_DABBLE: begin
        conv_ctrl.dabble = 1'b1;
        iter_d           = iter_q + 6'd1;
        if (iter_q == 6'd63) begin
          state_d = rdf_pkg::ST_ADJUST;
        end
      end

      rdf_pkg::ST_ADJUST: begin
        pos_d    = 6'(dfin - 7'd1);
        rem_d    = dfin - 7'd1;
        sep_en_d = (group_q != 7'd0) && (sep_char_q != 8'd0) && !small_hit;
        state_d  = sep_en_d ? rdf_pkg::ST_GROUP : rdf_pkg::ST_DIGIT;
      end

      // Reduce the top position modulo the group size by repeated subtraction.
      rdf_pkg::ST_GROUP: begin
        if (rem_q >= group_q) begin
          rem_d = rem_q - group_q;
        end else begin
          state_d = rdf_pkg::ST_DIGIT;
        end
      end

      rdf_pkg::ST_DIGIT: begin
        chr_req.valid = 1'b1;
        chr_req.data  = dchar;
        chr_req.last  = (pos_q == 6'd0);
        if (chr_ready) begin
          if (pos_q == 6'd0) begin
            state_d = rdf_pkg::ST_IDLE;
          end else if (sep_en_q && (rem_q == 7'd0)) begin
            state_d = rdf_pkg::ST_SEP;
          end else begin
            pos_d = pos_q - 6'd1;
            rem_d = rem_q - 7'd1;
          end
        end
      end

      rdf_pkg::ST_SEP: begin
        chr_req.valid = 1'b1;
        chr_req.data  = sep_char_q;
        if (chr_ready) begin
          pos_d   = pos_q - 6'd1;
          rem_d   = group_q - 7'd1;
          state_d = rdf_pkg::ST_DIGIT;
        end
      end

      default: state_d = rdf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rdf_pkg::ST_IDLE;
      iter_q   <= '0;
      sep_en_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      iter_q   <= iter_d;
      sep_en_q <= sep_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    pad_q    <= pad_d;
    size_q   <= size_d;
    mag_q    <= mag_d;
    digits_q <= digits_d;
    pos_q    <= pos_d;
    rem_q    <= rem_d;
  end

  rdf_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (conv_ctrl),
    .base_i      (base_q),
    .value_i     (mag_in),
    .rest_zero_o (rest_zero),
    .bcd_o       (bcd)
  );

  rdf_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .chr_i         (chr_req),
    .chr_ready_o   (chr_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ rtl/rdf_conv.sv @@
// ----------------------------------------------------------------------------
// rdf_conv
// Shared shift unit: counts digits by shifting the magnitude right one digit
// a cycle, or builds the decimal digits one bit a cycle (shift and add 3).
// ----------------------------------------------------------------------------
module rdf_conv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rdf_pkg::rdf_conv_ctrl_t           ctrl_i,
  input  rdf_pkg::rdf_base_e                base_i,
  input  logic [rdf_pkg::VALUE_BITS-1:0]    value_i,
  output logic                              rest_zero_o,
  output logic [rdf_pkg::BCD_BITS-1:0]      bcd_o
);

  logic [rdf_pkg::VALUE_BITS-1:0] sh_q, sh_d;
  logic [rdf_pkg::BCD_BITS-1:0]   bcd_q, bcd_d;
  logic [rdf_pkg::BCD_BITS-1:0]   bcd_adj;
  logic [rdf_pkg::VALUE_BITS-1:0] sh_digit;

  // Magnitude with the lowest digit of the current base removed.
  always_comb begin
    case (base_i)
      rdf_pkg::BASE_HEX: sh_digit = sh_q >> 4;
      rdf_pkg::BASE_OCT: sh_digit = sh_q >> 3;
      default:           sh_digit = sh_q >> 1;
    endcase
  end

  always_comb begin
    for (int k = 0; k < rdf_pkg::BCD_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  always_comb begin
    sh_d  = sh_q;
    bcd_d = bcd_q;
    if (ctrl_i.load) begin
      sh_d  = value_i;
      bcd_d = '0;
    end else if (ctrl_i.count) begin
      sh_d = sh_digit;
    end else if (ctrl_i.dabble) begin
      sh_d  = {sh_q[rdf_pkg::VALUE_BITS-2:0], 1'b0};
      bcd_d = {bcd_adj[rdf_pkg::BCD_BITS-2:0], sh_q[rdf_pkg::VALUE_BITS-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q  <= '0;
      bcd_q <= '0;
    end else begin
      sh_q  <= sh_d;
      bcd_q <= bcd_d;
    end
  end

  assign rest_zero_o = (sh_digit == '0);
  assign bcd_o       = bcd_q;

endmodule

@@ rtl/rdf_packer.sv @@
// ----------------------------------------------------------------------------
// rdf_packer
// Packs characters eight to a word (fewer in a number's last word) and holds the
// finished word in an output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module rdf_packer (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rdf_pkg::rdf_char_req_t  chr_i,
  output logic                    chr_ready_o,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [71:0]             m_axis_tdata,
  output logic                    m_axis_tlast
);

  logic [63:0] buf_q, buf_d;
  logic [2:0]  fill_q, fill_d;
  logic        ovalid_q, ovalid_d;
  logic [63:0] ochars_q, ochars_d;
  logic [3:0]  ocount_q, ocount_d;
  logic        olast_q, olast_d;
  logic [63:0] merged;
  logic        take;
  logic        flush;

  assign chr_ready_o = !ovalid_q || m_axis_tready;
  assign take        = chr_i.valid && chr_ready_o;
  assign flush       = (fill_q == 3'd7) || chr_i.last;
  assign merged      = buf_q | ({56'd0, chr_i.data} << {fill_q, 3'b000});

  always_comb begin
    buf_d    = buf_q;
    fill_d   = fill_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    ochars_d = ochars_q;
    ocount_d = ocount_q;
    olast_d  = olast_q;
    if (take) begin
      if (flush) begin
        ovalid_d = 1'b1;
        ochars_d = merged;
        ocount_d = {1'b0, fill_q} + 4'd1;
        olast_d  = chr_i.last;
        buf_d    = '0;
        fill_d   = '0;
      end else begin
        buf_d  = merged;
        fill_d = fill_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q    <= '0;
      fill_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      buf_q    <= buf_d;
      fill_q   <= fill_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ochars_q <= ochars_d;
    ocount_q <= ocount_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'd0, ocount_q, ochars_q};
  assign m_axis_tlast  = olast_q;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radix digit formatter core. Numbers of every
// size and base are streamed in under a series of register settings; a
// scoreboard formats each accepted number itself and compares every output
// word, in order, with the words it predicts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 800_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_PHASES = 7;
  localparam int unsigned PHASE_ITEMS   = 36;

  // Predicts the text words of each accepted number and checks them in order.
  class text_word_board;
    typedef struct {
      logic [63:0] chars;
      logic [3:0]  count;
      logic        last;
    } text_word_t;

    rdf_base_e   base;
    logic [6:0]  group_size;
    logic [7:0]  sep_char;
    bit          upper_hex;
    bit          hex_lead_zero;
    bit          small_hex_dec;
    bit          oct_prefix;

    logic [63:0] magnitude;
    logic [3:0]  dec_digits [20];
    text_word_t  pending_words [$];
    int unsigned error_count;

    function new();
      base          = BASE_HEX;
      group_size    = '0;
      sep_char      = '0;
      upper_hex     = 1'b1;
      hex_lead_zero = 1'b0;
      small_hex_dec = 1'b0;
      oct_prefix    = 1'b0;
      magnitude     = '0;
      foreach (dec_digits[k]) dec_digits[k] = '0;
      error_count   = 0;
    endfunction

    function void set_register(rdf_cfg_idx_e idx, logic [7:0] data);
      case (idx)
        CFG_NUMBER_BASE:       base          = rdf_base_e'(data[1:0]);
        CFG_GROUP_SIZE:        group_size    = data[6:0];
        CFG_SEPARATOR_CHAR:    sep_char      = data;
        CFG_UPPERCASE_HEX:     upper_hex     = data[0];
        CFG_HEX_LEADING_ZERO:  hex_lead_zero = data[0];
        CFG_SMALL_HEX_DECIMAL: small_hex_dec = data[0];
        CFG_OCTAL_ZERO_PREFIX: oct_prefix    = data[0];
        default: ;
      endcase
    endfunction

    // Digit at position pos, counted from the least significant digit.
    function int unsigned digit_value(rdf_base_e b, int unsigned pos);
      case (b)
        BASE_HEX: return pos >= 16 ? 0 : int'((magnitude >> (pos * 4)) & 64'hF);
        BASE_DEC: return pos >= 20 ? 0 : int'(dec_digits[pos]);
        BASE_OCT: return pos >= 22 ? 0 : int'((magnitude >> (pos * 3)) & 64'h7);
        default:  return pos >= 64 ? 0 : int'(magnitude[pos]);
      endcase
    endfunction

    function void note_number(logic [63:0] value, logic [1:0] size_code, logic is_signed,
                              logic pad);
      int unsigned width, ndig, shift, pos, d, fill;
      logic [63:0] mask, raw, rest, word;
      logic [7:0]  text [$];
      bit          use_sep;
      text_word_t  w;
      width   = 8 << size_code;
      mask    = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
      raw     = value & mask;
      use_sep = (group_size != 0) && (sep_char != 0);
      if (is_signed && raw[width-1]) begin
        text.push_back(CHAR_MINUS);
        magnitude = (~raw + 64'd1) & mask;
      end else begin
        magnitude = raw;
      end

      if (base == BASE_HEX && small_hex_dec && magnitude <= 64'd9) begin
        text.push_back(CHAR_ZERO + magnitude[7:0]);
      end else begin
        if (base == BASE_DEC) begin
          foreach (dec_digits[k]) dec_digits[k] = '0;
          rest = magnitude;
          ndig = 0;
          do begin
            dec_digits[ndig] = 4'(rest % 64'd10);
            rest = rest / 64'd10;
            ndig++;
          end while (rest != 0 && ndig < 20);
        end else begin
          shift = (base == BASE_HEX) ? 4 : ((base == BASE_OCT) ? 3 : 1);
          if (pad) begin
            ndig = (base == BASE_HEX) ? (width + 3) >> 2 :
                   ((base == BASE_OCT) ? (width + 2) / 3 : width);
          end else begin
            ndig = 1;
            rest = magnitude >> shift;
            while (rest != 0) begin
              ndig++;
              rest = rest >> shift;
            end
          end
          // Extra zero in front of a letter on top, or of a nonzero octal top digit.
          if (base == BASE_HEX && hex_lead_zero && ndig < 17 &&
              digit_value(BASE_HEX, ndig - 1) > 9)
            ndig++;
          if (base == BASE_OCT && oct_prefix && ndig < 23 &&
              digit_value(BASE_OCT, ndig - 1) != 0)
            ndig++;
        end
        for (int unsigned i = 0; i < ndig; i++) begin
          pos = ndig - 1 - i;
          d   = digit_value(base, pos);
          if (d > 9) begin
            text.push_back(8'(d) + (upper_hex ? HEX_UPPER_OFFS : HEX_LOWER_OFFS));
          end else begin
            text.push_back(8'(d) + CHAR_ZERO);
          end
          if (use_sep && pos > 0 && (pos % group_size) == 0) text.push_back(sep_char);
        end
      end

      word = '0;
      fill = 0;
      foreach (text[k]) begin
        word[fill*8 +: 8] = text[k];
        fill++;
        if (fill == 8 || k == text.size() - 1) begin
          w.chars = word;
          w.count = 4'(fill);
          w.last  = (k == text.size() - 1);
          pending_words.push_back(w);
          word = '0;
          fill = 0;
        end
      end
    endfunction

    function void check_word(logic [63:0] chars, logic [3:0] count, logic last);
      text_word_t w;
      if (pending_words.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected word: chars %h count %0d last %0b", chars, count, last);
        return;
      end
      w = pending_words.pop_front();
      if (chars !== w.chars || count !== w.count || last !== w.last) begin
        error_count++;
        if (error_count <= 10)
          $display("word mismatch: chars %h/%h count %0d/%0d last %0b/%0b (expected/actual)",
                   w.chars, chars, w.count, count, w.last, last);
      end
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned    src_idle_pct  = 27;
  int unsigned    sink_idle_pct = 27;
  bit             sink_hold_req = 1'b0;
  text_word_board board = new();

  radix_digit_formatter_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold when requested.
  initial begin : sink
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int unsigned k = 0; k < HOLD_CYCLES; k++) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast);
  end

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task automatic write_register(rdf_cfg_idx_e idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_register(idx, data);
  endtask

  task automatic set_format(rdf_base_e b, logic [6:0] grp, logic [7:0] sep, bit upper,
                            bit hex_zero, bit small_dec, bit oct_zero);
    write_register(CFG_NUMBER_BASE, 8'(b));
    write_register(CFG_GROUP_SIZE, {1'b0, grp});
    write_register(CFG_SEPARATOR_CHAR, sep);
    write_register(CFG_UPPERCASE_HEX, 8'(upper));
    write_register(CFG_HEX_LEADING_ZERO, 8'(hex_zero));
    write_register(CFG_SMALL_HEX_DECIMAL, 8'(small_dec));
    write_register(CFG_OCTAL_ZERO_PREFIX, 8'(oct_zero));
    cfg_valid_i <= 1'b0;
  endtask

  // Leaves s_axis_tvalid high so back-to-back requests need no extra edge.
  task automatic send_number(logic [63:0] value, logic [1:0] size_code, logic is_signed,
                             logic pad);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= {pad, is_signed, size_code};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_number(value, size_code, is_signed, pad);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = v & 64'h1F;                     // small magnitudes
      1: v = v | ~64'hF;                     // small negatives at any size
      2: v = 64'd1 << $urandom_range(63);    // single bit, hits the most negative values
      3: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    logic [6:0] grp;
    logic [7:0] sep;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset format: upper-case hex, no grouping.
    send_number(64'h0, 2'd0, 1'b0, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 1'b1, 1'b0);
    send_number(64'h8000_0000_0000_0000, 2'd3, 1'b1, 1'b1);
    send_number(64'h0000_0000_0000_00AB, 2'd0, 1'b0, 1'b1);
    wait_drained();

    // Decimal ignores padding; the most negative 64-bit value.
    set_format(BASE_DEC, 7'd3, ",", 1'b0, 1'b0, 1'b1, 1'b1);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 1'b0, 1'b1);
    send_number(64'h8000_0000_0000_0000, 2'd3, 1'b1, 1'b0);
    send_number(64'h0000_0000_0000_0080, 2'd0, 1'b1, 1'b0);
    send_number(64'h0, 2'd1, 1'b0, 1'b1);
    wait_drained();

    // Small hex as one decimal digit, and the leading zero on a padded number.
    set_format(BASE_HEX, 7'd4, "_", 1'b0, 1'b1, 1'b1, 1'b0);
    send_number(64'h9, 2'd0, 1'b0, 1'b1);
    send_number(64'hF7, 2'd0, 1'b1, 1'b1);
    send_number(64'hA, 2'd0, 1'b0, 1'b1);
    send_number(64'hF000_0000_0000_0000, 2'd3, 1'b0, 1'b1);
    send_number(64'hFFFF, 2'd1, 1'b0, 1'b0);
    wait_drained();

    // Octal prefix on a padded 64-bit number, and with a zero top digit.
    set_format(BASE_OCT, 7'd3, " ", 1'b1, 1'b1, 1'b0, 1'b1);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 1'b0, 1'b1);
    send_number(64'h7, 2'd0, 1'b0, 1'b0);
    send_number(64'h0, 2'd2, 1'b0, 1'b0);
    send_number(64'hFF, 2'd0, 1'b1, 1'b1);
    wait_drained();

    // Longest text: sign, 64 binary digits and 63 separators fill 16 words.
    set_format(BASE_BIN, 7'd1, ".", 1'b1, 1'b0, 1'b0, 1'b0);
    send_number(64'h8000_0000_0000_0000, 2'd3, 1'b1, 1'b0);
    send_number(64'h5A, 2'd0, 1'b0, 1'b1);
    send_number(64'h0, 2'd3, 1'b0, 1'b1);
    wait_drained();

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(4))
        0:       grp = 7'd0;
        1:       grp = 7'd127;
        2:       grp = 7'd64;
        default: grp = 7'($urandom_range(1, 8));
      endcase
      case ($urandom_range(3))
        0:       sep = 8'h00;
        1:       sep = 8'hFF;
        default: sep = 8'($urandom_range(33, 126));
      endcase
      set_format(rdf_base_e'($urandom_range(3)), grp, sep, 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      src_idle_pct  = (phase == 1) ? 0 : 27;
      sink_idle_pct = (phase == 1) ? 0 : 27;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == 4) sink_hold_req = 1'b1;
        send_number(pick_value(), 2'($urandom_range(3)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end
      wait_drained();
    end

    if (board.error_count == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
